>>> sv/svf_pkg.sv
// shared types, widths and constants of the self-regulating vent flow block
package svf_pkg;

  localparam int unsigned DPW        = 32;
  localparam int unsigned DENW       = 24;
  localparam int unsigned CFGW       = 32;
  localparam int unsigned OUTW       = 48;
  localparam int unsigned DTW        = 56;
  localparam int unsigned MW         = 38;
  localparam int unsigned QNW        = 64;
  localparam int unsigned QDIV_STEPS = 64;
  localparam int unsigned QREMW      = 38;
  localparam int unsigned ROOTW      = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned SREMW      = 34;
  localparam int unsigned PRODW      = 88;
  localparam int unsigned RDW        = 41;
  localparam int unsigned RD_STEPS   = 48;

  typedef enum logic [1:0] {
    CFG_TARGET_FLOW,
    CFG_P_MIN,
    CFG_P_MAX,
    CFG_DP_MIN
  } cfg_idx_e;

  localparam logic [CFGW-1:0] TARGET_FLOW_RST = 32'd167772;
  localparam logic [CFGW-1:0] P_MIN_RST       = 32'd65536;
  localparam logic [CFGW-1:0] P_MAX_RST       = 32'd3276800;
  localparam logic [CFGW-1:0] DP_MIN_RST      = 32'd66;
  localparam logic [CFGW-1:0] P_MIN_DEFAULT   = 32'd65536;
  localparam logic [MW-1:0]   P_MAX_FACTOR    = 38'd50;

  localparam logic [RDW-1:0]  FLOW_OVF_DIV    = 41'h1000000;
  localparam logic [RDW-1:0]  FLOW_BAND_DIV   = 41'd256;
  localparam logic [RDW-1:0]  SLOPE_BAND_DIV  = 41'd100000000;

  localparam logic [OUTW-1:0] POS_CAP = 48'h7FFFFFFFFFFF;
  localparam logic [OUTW-1:0] NEG_CAP = 48'h800000000000;

  typedef struct packed {
    logic [CFGW-1:0] target_flow;
    logic [CFGW-1:0] p_min;
    logic [CFGW-1:0] p_max;
    logic [CFGW-1:0] dp_min;
  } cfg_t;

  typedef struct packed {
    logic            neg;
    logic            lin;
    logic            ovf;
    logic [DPW-1:0]  a;
    logic [DENW-1:0] dens;
    logic [CFGW-1:0] pe;
    logic [DTW-1:0]  dt;
  } ctx_t;

endpackage

>>> sv/self_regulating_vent_flow_top.sv
// top level of the self-regulating vent flow pipeline with registers and output skid
// One word enters per clock while in_stall_o is low, and passes 2 front stages,
// 64 ratio divider stages, 32 square root stages, 2 multiply stages, 49 stages of the
// two-lane output divider and the output register. Stalls aside, one word per cycle.
// The output has a register and a skid stage; in_stall_o rises only when both hold a
// word that the consumer has not yet taken, and the whole pipeline then holds still.
// Configuration registers are read straight by the pipeline, so write them only while
// no word is in flight.
module self_regulating_vent_flow_top import svf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [DPW-1:0] delta_p_i,
  input  logic [DENW-1:0]       density_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [OUTW-1:0] mass_flow_o,
  output logic [OUTW-1:0]       flow_slope_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFGW-1:0]       cfg_data_i
);

  cfg_t             cfg_q;
  cfg_idx_e         cfg_idx;
  logic             en;

  logic             fr_valid;
  ctx_t             fr_ctx;
  logic [MW-1:0]    fr_pmax;
  logic             qd_valid;
  ctx_t             qd_ctx;
  logic [QNW-1:0]   qd_quo;
  logic             sq_valid;
  ctx_t             sq_ctx;
  logic [ROOTW-1:0] sq_root;
  logic             mu_valid, mu_neg;
  logic [PRODW-1:0] mu_nf, mu_ns;
  logic [RDW-1:0]   mu_df, mu_ds;
  logic             rd_valid, rd_neg;
  logic [OUTW-1:0]  rd_qf, rd_qs;

  logic [OUTW-1:0]  mf_d;
  logic [OUTW-1:0]  fl;
  logic             ov_q, skid_full_q;
  logic [OUTW-1:0]  omf_q, osl_q, smf_q, ssl_q;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_flow <= TARGET_FLOW_RST;
      cfg_q.p_min       <= P_MIN_RST;
      cfg_q.p_max       <= P_MAX_RST;
      cfg_q.dp_min      <= DP_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_TARGET_FLOW: cfg_q.target_flow <= cfg_data_i;
        CFG_P_MIN:       cfg_q.p_min       <= cfg_data_i;
        CFG_P_MAX:       cfg_q.p_max       <= cfg_data_i;
        CFG_DP_MIN:      cfg_q.dp_min      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  svf_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .delta_p_i, .density_i, .cfg_i(cfg_q),
    .valid_o(fr_valid), .ctx_o(fr_ctx), .pmax_o(fr_pmax)
  );

  svf_qdiv u_qdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .ctx_i(fr_ctx), .den_i(fr_pmax),
    .valid_o(qd_valid), .ctx_o(qd_ctx), .quo_o(qd_quo)
  );

  svf_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(qd_valid), .ctx_i(qd_ctx), .x_i(qd_quo),
    .valid_o(sq_valid), .ctx_o(sq_ctx), .root_o(sq_root)
  );

  svf_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .ctx_i(sq_ctx), .root_i(sq_root),
    .valid_o(mu_valid), .neg_o(mu_neg), .nf_o(mu_nf), .df_o(mu_df),
    .ns_o(mu_ns), .ds_o(mu_ds)
  );

  svf_rdiv u_rdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mu_valid), .neg_i(mu_neg),
    .nf_i(mu_nf), .df_i(mu_df), .ns_i(mu_ns), .ds_i(mu_ds),
    .valid_o(rd_valid), .neg_o(rd_neg), .qf_o(rd_qf), .qs_o(rd_qs)
  );

  // sign and saturation, rounding toward zero
  always_comb begin
    if (rd_neg) begin
      fl   = (rd_qf > NEG_CAP) ? NEG_CAP : rd_qf;
      mf_d = 48'd0 - fl;
    end else begin
      fl   = (rd_qf > POS_CAP) ? POS_CAP : rd_qf;
      mf_d = fl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q        <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (!skid_full_q) begin
      if (ov_q && out_stall_i) begin
        skid_full_q <= rd_valid;
      end else begin
        ov_q <= rd_valid;
      end
    end else if (!out_stall_i) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      if (ov_q && out_stall_i) begin
        smf_q <= mf_d;
        ssl_q <= rd_qs;
      end else begin
        omf_q <= mf_d;
        osl_q <= rd_qs;
      end
    end else if (!out_stall_i) begin
      omf_q <= smf_q;
      osl_q <= ssl_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign mass_flow_o  = omf_q;
  assign flow_slope_o = osl_q;

endmodule

>>> sv/svf_front.sv
// front stages: magnitude, effective pressures, density times target and region select
module svf_front import svf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [DPW-1:0]  delta_p_i,
  input  logic [DENW-1:0]        density_i,
  input  cfg_t                   cfg_i,
  output logic                   valid_o,
  output ctx_t                   ctx_o,
  output logic [MW-1:0]          pmax_o
);

  logic            va_q;
  logic            neg_q, neg_d;
  logic [DPW-1:0]  a_q, a_d;
  logic [CFGW-1:0] pe_q, pe_d;
  logic [MW-1:0]   me_q, me_d;
  logic [DENW-1:0] dens_q;
  logic [DPW-1:0]  raw;
  logic [MW-1:0]   pe50;

  logic            vb_q;
  ctx_t            ctx_q, ctx_d;
  logic [MW-1:0]   meb_q;

  always_comb begin
    raw   = delta_p_i;
    neg_d = raw[DPW-1];
    a_d   = neg_d ? (32'd0 - raw) : raw;
    pe_d  = (cfg_i.p_min == '0) ? P_MIN_DEFAULT : cfg_i.p_min;
    pe50  = MW'(pe_d) * P_MAX_FACTOR;
    me_d  = (cfg_i.p_max <= pe_d) ? pe50 : MW'(cfg_i.p_max);
  end

  always_comb begin
    ctx_d.neg  = neg_q;
    ctx_d.lin  = (a_q < cfg_i.dp_min) || (a_q < pe_q);
    ctx_d.ovf  = !ctx_d.lin && (MW'(a_q) > me_q);
    ctx_d.a    = a_q;
    ctx_d.dens = dens_q;
    ctx_d.pe   = pe_q;
    ctx_d.dt   = DTW'(dens_q) * DTW'(cfg_i.target_flow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= neg_d;
      a_q    <= a_d;
      pe_q   <= pe_d;
      me_q   <= me_d;
      dens_q <= density_i;
      ctx_q  <= ctx_d;
      meb_q  <= me_q;
    end
  end

  assign valid_o = vb_q;
  assign ctx_o   = ctx_q;
  assign pmax_o  = meb_q;

endmodule

>>> sv/svf_qdiv.sv
// pipelined restoring divider for the pressure ratio |dp| * 2^32 / p_max
module svf_qdiv import svf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ctx_t           ctx_i,
  input  logic [MW-1:0]  den_i,
  output logic           valid_o,
  output ctx_t           ctx_o,
  output logic [QNW-1:0] quo_o
);

  logic [QDIV_STEPS-1:0] v_q;
  ctx_t                  c_q   [QDIV_STEPS];
  logic [QREMW-1:0]      rem_q [QDIV_STEPS];
  logic [QNW-1:0]        nq_q  [QDIV_STEPS];
  logic [MW-1:0]         d_q   [QDIV_STEPS];

  for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_step
    logic             v_in;
    ctx_t             c_in;
    logic [QREMW-1:0] rem_in;
    logic [QNW-1:0]   nq_in;
    logic [MW-1:0]    d_in;
    logic [QREMW:0]   t;
    logic [QREMW:0]   diff;
    logic             ge;
    logic [QREMW-1:0] rem_d;
    logic [QNW-1:0]   nq_d;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign c_in   = ctx_i;
      assign rem_in = '0;
      assign nq_in  = {ctx_i.a, 32'd0};
      assign d_in   = den_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign c_in   = c_q[k-1];
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign d_in   = d_q[k-1];
    end

    always_comb begin
      t     = {rem_in, nq_in[QNW-1]};
      diff  = t - {1'b0, d_in};
      ge    = t >= {1'b0, d_in};
      rem_d = ge ? diff[QREMW-1:0] : t[QREMW-1:0];
      nq_d  = {nq_in[QNW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k]   <= c_in;
        rem_q[k] <= rem_d;
        nq_q[k]  <= nq_d;
        d_q[k]   <= d_in;
      end
    end
  end

  assign valid_o = v_q[QDIV_STEPS-1];
  assign ctx_o   = c_q[QDIV_STEPS-1];
  assign quo_o   = nq_q[QDIV_STEPS-1];

endmodule

>>> sv/svf_isqrt.sv
// pipelined integer square root, two radicand bits per stage
module svf_isqrt import svf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ctx_t             ctx_i,
  input  logic [QNW-1:0]   x_i,
  output logic             valid_o,
  output ctx_t             ctx_o,
  output logic [ROOTW-1:0] root_o
);

  logic [SQRT_STEPS-1:0] v_q;
  ctx_t                  c_q    [SQRT_STEPS];
  logic [SREMW-1:0]      rem_q  [SQRT_STEPS];
  logic [ROOTW-1:0]      root_q [SQRT_STEPS];
  logic [QNW-1:0]        x_q    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic             v_in;
    ctx_t             c_in;
    logic [SREMW-1:0] rem_in;
    logic [ROOTW-1:0] root_in;
    logic [QNW-1:0]   x_in;
    logic [SREMW+1:0] t;
    logic [SREMW+1:0] trial;
    logic [SREMW+1:0] diff;
    logic             ge;
    logic [SREMW-1:0] rem_d;
    logic [ROOTW-1:0] root_d;
    logic [QNW-1:0]   x_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign c_in    = ctx_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign c_in    = c_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    always_comb begin
      t      = {rem_in, x_in[QNW-1:QNW-2]};
      trial  = {2'b00, root_in, 2'b01};
      diff   = t - trial;
      ge     = t >= trial;
      rem_d  = ge ? diff[SREMW-1:0] : t[SREMW-1:0];
      root_d = {root_in[ROOTW-2:0], ge};
      x_d    = {x_in[QNW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k]    <= c_in;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        x_q[k]    <= x_d;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign ctx_o   = c_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];

endmodule

>>> sv/svf_mul.sv
// split product of density-target by the law factor, then divider operand select
module svf_mul import svf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ctx_t             ctx_i,
  input  logic [ROOTW-1:0] root_i,
  output logic             valid_o,
  output logic             neg_o,
  output logic [PRODW-1:0] nf_o,
  output logic [RDW-1:0]   df_o,
  output logic [PRODW-1:0] ns_o,
  output logic [RDW-1:0]   ds_o
);

  logic             v1_q;
  ctx_t             c1_q;
  logic [63:0]      pl_q, pl_d;
  logic [DTW-1:0]   ph_q, ph_d;
  logic [31:0]      m;

  logic             v2_q;
  logic             neg_q;
  logic [PRODW-1:0] nf_q, nf_d, ns_q, ns_d;
  logic [RDW-1:0]   df_q, df_d, ds_q, ds_d;
  logic [PRODW-1:0] prod;

  always_comb begin
    m    = ctx_i.ovf ? root_i : (ctx_i.lin ? ctx_i.a : 32'd1);
    // low 32 and high 24 bits of the density-target product
    pl_d = 64'(ctx_i.dt[31:0]) * 64'(m);
    ph_d = DTW'(ctx_i.dt[DTW-1:32]) * DTW'(m);
  end

  always_comb begin
    prod = PRODW'(pl_q) + {ph_q, 32'd0};
    nf_d = prod;
    if (c1_q.ovf) begin
      df_d = FLOW_OVF_DIV;
      ns_d = prod;
      ds_d = {c1_q.a, 9'd0};
    end else if (c1_q.lin) begin
      df_d = {1'b0, c1_q.pe, 8'd0};
      ns_d = PRODW'({c1_q.dt, 8'd0});
      ds_d = RDW'(c1_q.pe);
    end else begin
      df_d = FLOW_BAND_DIV;
      ns_d = PRODW'({c1_q.dens, 16'd0});
      ds_d = SLOPE_BAND_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q  <= ctx_i;
      pl_q  <= pl_d;
      ph_q  <= ph_d;
      neg_q <= c1_q.neg;
      nf_q  <= nf_d;
      df_q  <= df_d;
      ns_q  <= ns_d;
      ds_q  <= ds_d;
    end
  end

  assign valid_o = v2_q;
  assign neg_o   = neg_q;
  assign nf_o    = nf_q;
  assign df_o    = df_q;
  assign ns_o    = ns_q;
  assign ds_o    = ds_q;

endmodule

>>> sv/svf_rdiv.sv
// two-lane pipelined divider with 48-bit saturated quotients for flow and slope
module svf_rdiv import svf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic             neg_i,
  input  logic [PRODW-1:0] nf_i,
  input  logic [RDW-1:0]   df_i,
  input  logic [PRODW-1:0] ns_i,
  input  logic [RDW-1:0]   ds_i,
  output logic             valid_o,
  output logic             neg_o,
  output logic [OUTW-1:0]  qf_o,
  output logic [OUTW-1:0]  qs_o
);

  logic [RD_STEPS:0]  v_q;
  logic [RD_STEPS:0]  neg_q;
  logic [PRODW-1:0]   num_in [2];
  logic [RDW-1:0]     den_in [2];
  logic [OUTW-1:0]    quo    [2];

  assign num_in[0] = nf_i;
  assign den_in[0] = df_i;
  assign num_in[1] = ns_i;
  assign den_in[1] = ds_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RD_STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= {neg_q[RD_STEPS-1:0], neg_i};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [RDW-1:0]  rem_q [RD_STEPS+1];
    logic [OUTW-1:0] low_q [RD_STEPS+1];
    logic [RDW-1:0]  d_q   [RD_STEPS+1];
    logic            sat_q [RD_STEPS+1];
    logic [RDW-1:0]  top0;

    // quotient overflows 48 bits when the bits above them already reach the divisor
    assign top0 = {1'b0, num_in[l][PRODW-1:OUTW]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= top0;
        low_q[0] <= num_in[l][OUTW-1:0];
        d_q[0]   <= den_in[l];
        sat_q[0] <= top0 >= den_in[l];
      end
    end

    for (genvar k = 1; k <= RD_STEPS; k++) begin : g_step
      logic [RDW:0]    t;
      logic [RDW:0]    diff;
      logic            ge;
      logic [RDW-1:0]  rem_d;
      logic [OUTW-1:0] low_d;

      always_comb begin
        t     = {rem_q[k-1], low_q[k-1][OUTW-1]};
        diff  = t - {1'b0, d_q[k-1]};
        ge    = t >= {1'b0, d_q[k-1]};
        rem_d = ge ? diff[RDW-1:0] : t[RDW-1:0];
        low_d = {low_q[k-1][OUTW-2:0], ge};
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          low_q[k] <= low_d;
          d_q[k]   <= d_q[k-1];
          sat_q[k] <= sat_q[k-1];
        end
      end
    end

    assign quo[l] = sat_q[RD_STEPS] ? {OUTW{1'b1}} : low_q[RD_STEPS];
  end

  assign valid_o = v_q[RD_STEPS];
  assign neg_o   = neg_q[RD_STEPS];
  assign qf_o    = quo[0];
  assign qs_o    = quo[1];

endmodule

>>> sv/svf_check.sv
// port-level checker for the vent flow top level, with its bind
module svf_check import svf_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [OUTW-1:0] mass_flow_o,
  input logic [OUTW-1:0]        flow_slope_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mass_flow_o) &&
    $stable(flow_slope_o))
    else $error("stalled result word changed");

  // input stall only while a result waits
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without output stall");

  // skid empties in the cycle after the output is released
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output released");

endmodule

bind self_regulating_vent_flow_top svf_check u_svf_check (.*);
